@@ src/jiip_pkg.sv @@
// Shared types, constants and helpers for the Julia inverse-iteration point generator.
// No dependencies; every other file in src/ imports this package.
`default_nettype none

package jiip_pkg;

  localparam int FracBits   = 28;
  localparam int ScaleShift = 16 + FracBits;   // Q4.28 times Q16.16
  localparam int ProdTop    = 64;              // highest bit a plot product can reach
  localparam int QW         = ProdTop - ScaleShift + 1;
  localparam int SqrtSteps  = 32;

  localparam logic [12:0]        MaxDim    = 13'd4096;
  localparam logic [9:0]         FlipLimit = 10'd100;
  localparam logic signed [33:0] One       = 34'sd268435456;   // 1.0 in Q4.28
  localparam logic signed [33:0] Max32     = 34'sd2147483647;
  localparam logic signed [33:0] Min32     = -34'sd2147483648;

  // Register indexes (word address)
  localparam logic [2:0] RegCRe    = 3'd0;
  localparam logic [2:0] RegCIm    = 3'd1;
  localparam logic [2:0] RegViewX  = 3'd2;
  localparam logic [2:0] RegViewY  = 3'd3;
  localparam logic [2:0] RegScaleX = 3'd4;
  localparam logic [2:0] RegScaleY = 3'd5;
  localparam logic [2:0] RegWidth  = 3'd6;
  localparam logic [2:0] RegHeight = 3'd7;

  typedef struct packed {
    logic signed [30:0] c_re;
    logic signed [30:0] c_im;
    logic signed [31:0] view_x_min;
    logic signed [31:0] view_y_min;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic [12:0]        width;
    logic [12:0]        height;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_SQRT_M,
    OP_TAKE_M,
    OP_SQRT_RE,
    OP_TAKE_RE,
    OP_SQRT_IM,
    OP_TAKE_IM,
    OP_SEED,
    OP_PLOT_MUL,
    OP_PLOT_EVAL,
    OP_SGN_X,
    OP_SGN_Y,
    OP_UPDATE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   axis_y;   // plot: vertical axis
    logic   neg;      // plot: the point -z
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic sqrt_busy;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT_M,
    ST_WAIT_M,
    ST_TAKE_M,
    ST_SQRT_RE,
    ST_WAIT_RE,
    ST_TAKE_RE,
    ST_SQRT_IM,
    ST_WAIT_IM,
    ST_TAKE_IM,
    ST_SEED,
    ST_PLOT_MUL,
    ST_PLOT_EVAL,
    ST_SGN_X,
    ST_SGN_Y,
    ST_UPDATE,
    ST_EMIT
  } ctrl_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > Max32) begin
      r = Max32[31:0];
    end else if (v < Min32) begin
      r = Min32[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/jiip_sqrt.sv @@
// Iterative integer square root: floor(sqrt) of a 64-bit operand, one root bit per cycle.
// Depends on jiip_pkg.
`default_nettype none

module jiip_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] operand_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);
  import jiip_pkg::*;

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [63:0] op_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  logic [35:0] remx, trial;
  logic        ge;

  always_comb begin
    remx  = {rem_q, op_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    ge    = (remx >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(SqrtSteps - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= operand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(remx - trial) : 34'(remx);
      root_q <= {root_q[30:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ src/jiip_datapath.sv @@
// Datapath: operand registers, shared multiplier, square root unit, pixel mapping,
// point state and the output register. Depends on jiip_pkg and jiip_sqrt.
`default_nettype none

module jiip_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire jiip_pkg::cfg_t       cfg_i,
  input  wire jiip_pkg::dp_cmd_t    cmd_i,
  output jiip_pkg::dp_status_t      status_o,
  input  wire logic                 command_i,
  input  wire logic [9:0]           draw_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [11:0]               first_px_o,
  output logic [11:0]               first_py_o,
  output logic                      first_in_o,
  output logic [11:0]               second_px_o,
  output logic [11:0]               second_py_o,
  output logic                      second_in_o
);
  import jiip_pkg::*;

  logic               step_q;
  logic [9:0]         draw_q;
  logic signed [31:0] a_q, b_q, x_q, y_q, z_re_q, z_im_q;
  logic [31:0]        m_q, re_q;
  logic [63:0]        acc_q;
  logic signed [67:0] prod_q;
  logic               dneg_q;
  logic [11:0]        st_px_q [2];
  logic [11:0]        st_py_q [2];
  logic               st_xok_q [2];
  logic               st_yok_q [2];
  logic               out_valid_q;
  logic [11:0]        o_fpx_q, o_fpy_q, o_spx_q, o_spy_q;
  logic               o_fin_q, o_sin_q;

  // square root unit
  logic        sq_start, sq_busy;
  logic [63:0] sq_operand;
  logic [31:0] sq_root;

  jiip_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_operand),
    .busy_o    (sq_busy),
    .root_o    (sq_root)
  );

  logic signed [33:0] half_sum;
  always_comb begin
    sq_start   = 1'b0;
    sq_operand = '0;
    half_sum   = '0;
    case (cmd_i.op)
      OP_SQRT_M: begin
        sq_start   = 1'b1;
        sq_operand = acc_q + prod_q[63:0];
      end
      OP_SQRT_RE: begin
        sq_start   = 1'b1;
        half_sum   = ($signed({2'b00, m_q}) + 34'(a_q)) >>> 1;
        sq_operand = 64'(half_sum[32:0]) << FracBits;
      end
      OP_SQRT_IM: begin
        sq_start   = 1'b1;
        half_sum   = ($signed({2'b00, m_q}) - 34'(a_q)) >>> 1;
        sq_operand = 64'(half_sum[32:0]) << FracBits;
      end
      default: begin
      end
    endcase
  end

  // loads for a new transaction
  logic signed [33:0] load_a, load_b;
  always_comb begin
    if (command_i) begin
      load_a = 34'(z_re_q) + 34'(cfg_i.c_re);
      load_b = 34'(z_im_q) + 34'(cfg_i.c_im);
    end else begin
      load_a = One + (34'(cfg_i.c_re) <<< 2);
      load_b = 34'(cfg_i.c_im) <<< 2;
    end
  end

  // pixel mapping, multiply side
  logic signed [32:0] pt;
  logic signed [33:0] diff;
  logic               dneg;
  logic [32:0]        mag;
  logic [31:0]        scale;
  always_comb begin
    pt    = cmd_i.neg ? -33'(x_q) : 33'(x_q);
    scale = cfg_i.scale_x;
    diff  = 34'(pt) - 34'(cfg_i.view_x_min);
    if (cmd_i.axis_y) begin
      pt    = cmd_i.neg ? -33'(y_q) : 33'(y_q);
      scale = cfg_i.scale_y;
      diff  = 34'(pt) - 34'(cfg_i.view_y_min);
    end
    dneg = diff[33];
    mag  = dneg ? 33'(-diff) : 33'(diff);
  end

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ_A: begin
        mul_a = 34'(a_q);
        mul_b = 34'(a_q);
      end
      OP_SQ_B: begin
        mul_a = 34'(b_q);
        mul_b = 34'(b_q);
      end
      OP_PLOT_MUL: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({2'b00, scale});
      end
      OP_SGN_X: begin
        mul_a = 34'(x_q);
        mul_b = 34'(cfg_i.c_re);
      end
      OP_SGN_Y: begin
        mul_a = 34'(y_q);
        mul_b = 34'(cfg_i.c_im);
      end
      default: begin
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // pixel mapping, evaluate side
  logic [QW-1:0]      q;
  logic               inexact;
  logic [12:0]        wc, hc;
  logic signed [22:0] qs, fl, ce, hm1, sy;
  logic               xok, yok;
  always_comb begin
    q       = prod_q[ProdTop:ScaleShift];
    inexact = |prod_q[ScaleShift-1:0];
    wc      = (cfg_i.width  > MaxDim) ? MaxDim : cfg_i.width;
    hc      = (cfg_i.height > MaxDim) ? MaxDim : cfg_i.height;
    xok     = (!dneg_q || q == '0) && (q < QW'(wc));
    qs      = $signed(23'(q));
    fl      = dneg_q ? -qs - 23'(inexact) : qs;
    ce      = dneg_q ? -qs : qs + 23'(inexact);
    hm1     = $signed(23'(hc)) - 23'sd1;
    sy      = (ce <= hm1) ? hm1 - ce : hm1 - fl;
    yok     = !sy[22] && (sy < $signed(23'(hc)));
  end

  // seeding and sign choice
  logic signed [33:0] xt, yt;
  logic signed [31:0] seed_re, seed_im;
  logic signed [63:0] dot;
  logic               flip;
  always_comb begin
    xt = 34'(x_q);
    yt = 34'(y_q);
    if (xt <= One) begin
      seed_re = sat32((One + xt) >>> 1);
      seed_im = sat32(yt >>> 1);
    end else begin
      seed_re = sat32((One - xt) >>> 1);
      seed_im = sat32((-yt) >>> 1);
    end
    dot  = $signed(acc_q) + $signed(prod_q[63:0]);
    flip = (dot > 64'sd0) ^ (draw_q < FlipLimit);
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_re_q      <= '0;
      z_im_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SEED) begin
        z_re_q <= seed_re;
        z_im_q <= seed_im;
      end else if (cmd_i.op == OP_UPDATE) begin
        z_re_q <= flip ? sat32(-xt) : x_q;
        z_im_q <= flip ? sat32(-yt) : y_q;
      end
      if (cmd_i.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        step_q <= command_i;
        draw_q <= draw_i;
        a_q    <= sat32(load_a);
        b_q    <= sat32(load_b);
      end
      OP_SQ_A, OP_SGN_X: begin
        prod_q <= mul_p;
      end
      OP_SQ_B, OP_SGN_Y: begin
        acc_q  <= prod_q[63:0];
        prod_q <= mul_p;
      end
      OP_TAKE_M: begin
        m_q <= sq_root;
      end
      OP_TAKE_RE: begin
        re_q <= sq_root;
      end
      OP_TAKE_IM: begin
        // branch rule for a negative imaginary part
        x_q <= (b_q < 0 && a_q < 0)  ? -$signed(re_q)    : $signed(re_q);
        y_q <= (b_q < 0 && a_q >= 0) ? -$signed(sq_root) : $signed(sq_root);
      end
      OP_PLOT_MUL: begin
        prod_q <= mul_p;
        dneg_q <= dneg;
      end
      OP_PLOT_EVAL: begin
        if (cmd_i.axis_y) begin
          st_py_q[cmd_i.neg]  <= sy[11:0];
          st_yok_q[cmd_i.neg] <= yok;
        end else begin
          st_px_q[cmd_i.neg]  <= q[11:0];
          st_xok_q[cmd_i.neg] <= xok;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          o_fin_q <= st_xok_q[0] && st_yok_q[0];
          o_sin_q <= st_xok_q[1] && st_yok_q[1];
          o_fpx_q <= (st_xok_q[0] && st_yok_q[0]) ? st_px_q[0] : '0;
          o_fpy_q <= (st_xok_q[0] && st_yok_q[0]) ? st_py_q[0] : '0;
          o_spx_q <= (st_xok_q[1] && st_yok_q[1]) ? st_px_q[1] : '0;
          o_spy_q <= (st_xok_q[1] && st_yok_q[1]) ? st_py_q[1] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.restart   = !step_q;
  assign status_o.sqrt_busy = sq_busy;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign first_px_o  = o_fpx_q;
  assign first_py_o  = o_fpy_q;
  assign first_in_o  = o_fin_q;
  assign second_px_o = o_spx_q;
  assign second_py_o = o_spy_q;
  assign second_in_o = o_sin_q;

endmodule

`default_nettype wire

@@ src/jiip_ctrl.sv @@
// Controller: sequences one transaction through the datapath by issuing commands.
// Depends on jiip_pkg.
`default_nettype none

module jiip_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire jiip_pkg::dp_status_t status_i,
  output jiip_pkg::dp_cmd_t         cmd_o
);
  import jiip_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;   // plot pass: bit 0 axis, bit 1 point -z

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SQ_A;
      ST_SQ_A:      state_d = ST_SQ_B;
      ST_SQ_B:      state_d = ST_SQRT_M;
      ST_SQRT_M:    state_d = ST_WAIT_M;
      ST_WAIT_M:    if (!status_i.sqrt_busy) state_d = ST_TAKE_M;
      ST_TAKE_M:    state_d = ST_SQRT_RE;
      ST_SQRT_RE:   state_d = ST_WAIT_RE;
      ST_WAIT_RE:   if (!status_i.sqrt_busy) state_d = ST_TAKE_RE;
      ST_TAKE_RE:   state_d = ST_SQRT_IM;
      ST_SQRT_IM:   state_d = ST_WAIT_IM;
      ST_WAIT_IM:   if (!status_i.sqrt_busy) state_d = ST_TAKE_IM;
      ST_TAKE_IM: begin
        idx_d   = '0;
        state_d = status_i.restart ? ST_SEED : ST_PLOT_MUL;
      end
      ST_SEED:      state_d = ST_IDLE;
      ST_PLOT_MUL:  state_d = ST_PLOT_EVAL;
      ST_PLOT_EVAL: begin
        idx_d   = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? ST_SGN_X : ST_PLOT_MUL;
      end
      ST_SGN_X:     state_d = ST_SGN_Y;
      ST_SGN_Y:     state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_EMIT;
      ST_EMIT:      if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.op     = OP_NOP;
    cmd_o.axis_y = idx_q[0];
    cmd_o.neg    = idx_q[1];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_SQ_A:      cmd_o.op = OP_SQ_A;
      ST_SQ_B:      cmd_o.op = OP_SQ_B;
      ST_SQRT_M:    cmd_o.op = OP_SQRT_M;
      ST_TAKE_M:    cmd_o.op = OP_TAKE_M;
      ST_SQRT_RE:   cmd_o.op = OP_SQRT_RE;
      ST_TAKE_RE:   cmd_o.op = OP_TAKE_RE;
      ST_SQRT_IM:   cmd_o.op = OP_SQRT_IM;
      ST_TAKE_IM:   cmd_o.op = OP_TAKE_IM;
      ST_SEED:      cmd_o.op = OP_SEED;
      ST_PLOT_MUL:  cmd_o.op = OP_PLOT_MUL;
      ST_PLOT_EVAL: cmd_o.op = OP_PLOT_EVAL;
      ST_SGN_X:     cmd_o.op = OP_SGN_X;
      ST_SGN_Y:     cmd_o.op = OP_SGN_Y;
      ST_UPDATE:    cmd_o.op = OP_UPDATE;
      ST_EMIT:      cmd_o.op = OP_EMIT;
      default:      cmd_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ src/julia_inverse_iteration_point_gen.sv @@
// Julia set point generator by inverse iteration, signed Q4.28 fixed point.
// Input channel (in_valid_i/in_ready_o) carries command_i and draw_i. command 0 reseeds
// z from sqrt(1+4c) and gives no result; command 1 takes z to sqrt(z+c) and gives one
// transaction on the output channel (out_valid_o/out_ready_i) with the pixel position
// and in-view flag of z and of -z.
// Each transaction runs three square roots of 32 steps on one shared iterative unit; each
// root passes through start, its 32 steps, a wait for the unit to finish, and capture.
// The squares, pixel products and sign test share one multiplier. A restart ends by
// updating z and a step by loading the result register; the next transaction can be
// accepted from the following cycle.
// One transaction is in flight at a time; in_ready_o is high only when the sequencer idles.
// The output register decouples the sides: a waiting result does not block acceptance,
// but a step finishing while the previous result is still unread holds until it is taken.
// Reset (rst_ni, asynchronous, active low) clears z to zero, empties the output
// register and loads the configuration defaults. Configuration goes through the APB
// port at byte address 4*index and is to be written while the block is idle.
// Depends on jiip_pkg, jiip_ctrl, jiip_datapath and jiip_sqrt.
`default_nettype none

module julia_inverse_iteration_point_gen (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [9:0]  draw_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      first_px_o,
  output logic [11:0]      first_py_o,
  output logic             first_in_o,
  output logic [11:0]      second_px_o,
  output logic [11:0]      second_py_o,
  output logic             second_in_o
);
  import jiip_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_re       <= 31'sd53687091;
      cfg_q.c_im       <= 31'sd187904819;
      cfg_q.view_x_min <= -32'sd671088640;
      cfg_q.view_y_min <= -32'sd483183821;
      cfg_q.scale_x    <= 32'd8388608;
      cfg_q.scale_y    <= 32'd8738133;
      cfg_q.width      <= 13'd640;
      cfg_q.height     <= 13'd480;
    end else if (wr_en) begin
      case (reg_idx)
        RegCRe:    cfg_q.c_re       <= pwdata[30:0];
        RegCIm:    cfg_q.c_im       <= pwdata[30:0];
        RegViewX:  cfg_q.view_x_min <= pwdata;
        RegViewY:  cfg_q.view_y_min <= pwdata;
        RegScaleX: cfg_q.scale_x    <= pwdata;
        RegScaleY: cfg_q.scale_y    <= pwdata;
        RegWidth:  cfg_q.width      <= pwdata[12:0];
        RegHeight: cfg_q.height     <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCRe:    prdata = {1'b0, cfg_q.c_re};
      RegCIm:    prdata = {1'b0, cfg_q.c_im};
      RegViewX:  prdata = cfg_q.view_x_min;
      RegViewY:  prdata = cfg_q.view_y_min;
      RegScaleX: prdata = cfg_q.scale_x;
      RegScaleY: prdata = cfg_q.scale_y;
      RegWidth:  prdata = {19'd0, cfg_q.width};
      RegHeight: prdata = {19'd0, cfg_q.height};
      default:   prdata = '0;
    endcase
  end

  jiip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jiip_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .command_i   (command_i),
    .draw_i      (draw_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .first_px_o  (first_px_o),
    .first_py_o  (first_py_o),
    .first_in_o  (first_in_o),
    .second_px_o (second_px_o),
    .second_py_o (second_py_o),
    .second_in_o (second_in_o)
  );

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction is in progress");

  // the root unit is never left running once the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.sqrt_busy)
    else $error("square root unit busy while idle");

  // coordinates are cleared for points outside the view
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !first_in_o |-> first_px_o == '0 && first_py_o == '0)
    else $error("first point out of view but coordinates non-zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !second_in_o |-> second_px_o == '0 && second_py_o == '0)
    else $error("second point out of view but coordinates non-zero");

endmodule

`default_nettype wire
